[hw/rtl/aht_pkg.sv]
// shared types, codes and constants of the alarm hold-time tracker
`timescale 1ns / 1ps

package aht_pkg;

    localparam int ALARM_COUNT_DEF = 32;
    localparam int HOUR_BITS_DEF   = 16;
    localparam int IDX_W           = 5;
    localparam int WORD_W          = 32;
    localparam int TIME_W          = 6;
    localparam int HOURS_OUT_W     = 16;
    localparam int GRADE_W         = 3;
    localparam int ROLL_LIMIT      = 60;
    localparam int PRODUCER_FIRST  = 16;
    localparam int TICK_SLOTS      = 28;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    typedef struct packed {
        command_t             command;
        logic [IDX_W-1:0]     alarm_index;
        logic                 alarm_on;
        logic [GRADE_W-1:0]   alarm_grade;
        logic                 producer_active;
        logic                 stack_active;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0]      alarm_word;
        logic                   selected_state;
        logic [TIME_W-1:0]      hold_seconds;
        logic [TIME_W-1:0]      hold_minutes;
        logic [HOURS_OUT_W-1:0] hold_hours;
        logic                   beep_request;
        logic [GRADE_W-1:0]     beep_grade;
    } result_t;

    // access bundle from the sequencer to the hold-time memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             clr_all;
        logic             clr_one;
        logic [IDX_W-1:0] clr_addr;
    } mem_ctl_t;

endpackage

[hw/rtl/aht_hold_mem.sv]
// hold-time memory with per-entry valid bits and registered read
`timescale 1ns / 1ps

module aht_hold_mem
    import aht_pkg::*;
#(
    parameter int DEPTH  = ALARM_COUNT_DEF,
    parameter int DATA_W = 2 * TIME_W + HOUR_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_ctl_t          ctl,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    // an entry that is not valid reads as a cleared timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else
            begin
                if (ctl.clr_one)
                begin
                    valid_reg[ctl.clr_addr] <= 1'b0;
                end
                if (ctl.wr_en)
                begin
                    valid_reg[ctl.wr_addr] <= 1'b1;
                end
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/alarm_hold_time_tracker.sv]
// top level of the alarm hold-time tracker: command sequencer and result register
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. A tick item walks the
// 28 tick-driven hold timers through the timer memory, one entry read per
// cycle with the write-back of the previous entry overlapped, so busy stays
// high through the walk, drain, fetch and done states. Set, clear and read
// items need one memory read of the addressed timer: busy stays high through
// the fetch and done states. The result is on result for exactly one cycle,
// marked by result_valid, in the first cycle in which busy is low; it cannot
// be held off, and a new item may be started in that same cycle. Timers are
// cleared at reset and by a clear item through valid bits, so no clearing
// pass is needed.
module alarm_hold_time_tracker
    import aht_pkg::*;
#(
    parameter int ALARM_COUNT = ALARM_COUNT_DEF,
    parameter int HOUR_BITS   = HOUR_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     result_valid,
    output result_t  result
);

    localparam int ENTRY_W = 2 * TIME_W + HOUR_BITS;
    localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(TICK_SLOTS - 1);
    localparam logic [TIME_W-1:0] TIME_LAST = TIME_W'(ROLL_LIMIT - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    request_t                req_reg;
    logic                    idx_ok_reg, idx_ok_next;
    logic [ALARM_COUNT-1:0]  alarm_bits_reg, alarm_bits_next;
    logic [TICK_SLOTS-1:0]   elig_reg, elig_next;
    logic [IDX_W-1:0]        walk_cnt_reg, walk_cnt_next;
    logic                    wb_pend_reg, wb_pend_next;
    logic [IDX_W-1:0]        wb_addr_reg;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    accept;
    logic [WORD_W-1:0]       word_now;
    logic [WORD_W-1:0]       word_set;
    logic                    set_change;
    mem_ctl_t                mem_ctl;
    logic [ENTRY_W-1:0]      rd_data;
    logic [ENTRY_W-1:0]      wr_data;

    // fields of the entry coming out of the memory
    logic [TIME_W-1:0]       rd_sec, rd_min;
    logic [HOUR_BITS-1:0]    rd_hr;
    logic [TIME_W-1:0]       nx_sec, nx_min;
    logic [HOUR_BITS-1:0]    nx_hr;
    logic [WORD_W-1:0]       rd_hr_wide;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign word_now = WORD_W'(alarm_bits_reg);

    // set item: bit change and timer restart happen at the accept edge
    assign idx_ok_next = (int'(request.alarm_index) < ALARM_COUNT);

    always_comb
    begin
        word_set = word_now;
        word_set[request.alarm_index] = request.alarm_on;
    end

    assign set_change = accept && (request.command == CMD_SET) && idx_ok_next
                        && (word_now[request.alarm_index] != request.alarm_on);

    always_comb
    begin
        alarm_bits_next = alarm_bits_reg;
        if (accept && (request.command == CMD_CLEAR))
        begin
            alarm_bits_next = '0;
        end
        else if (set_change)
        begin
            alarm_bits_next = ALARM_COUNT'(word_set);
        end
    end

    // timers to advance on this tick: producer group 16..27, stack group 0..15
    always_comb
    begin
        elig_next = elig_reg;
        if (accept)
        begin
            for (int i = 0; i < TICK_SLOTS; i++)
            begin
                if (i >= PRODUCER_FIRST)
                begin
                    elig_next[i] = word_now[i] & request.producer_active;
                end
                else
                begin
                    elig_next[i] = word_now[i] & request.stack_active;
                end
            end
        end
    end

    // timer increment with rollover of seconds and minutes, hours wrap
    assign rd_sec = rd_data[TIME_W-1:0];
    assign rd_min = rd_data[2*TIME_W-1:TIME_W];
    assign rd_hr  = rd_data[ENTRY_W-1:2*TIME_W];

    always_comb
    begin
        nx_sec = rd_sec + TIME_W'(1);
        nx_min = rd_min;
        nx_hr  = rd_hr;
        if (rd_sec >= TIME_LAST)
        begin
            nx_sec = '0;
            nx_min = rd_min + TIME_W'(1);
            if (rd_min >= TIME_LAST)
            begin
                nx_min = '0;
                nx_hr  = rd_hr + HOUR_BITS'(1);
            end
        end
    end

    assign wr_data = {nx_hr, nx_min, nx_sec};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        wb_pend_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                walk_cnt_next = '0;
                if (accept)
                begin
                    if (request.command == CMD_TICK)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WALK:
            begin
                wb_pend_next  = 1'b1;
                walk_cnt_next = walk_cnt_reg + IDX_W'(1);
                if (walk_cnt_reg == WALK_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last write-back lands before the addressed timer is read
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory accesses: walk reads, write-back of the entry read before, final fetch, clears
    always_comb
    begin
        mem_ctl          = '0;
        mem_ctl.clr_all  = accept && (request.command == CMD_CLEAR);
        mem_ctl.clr_one  = set_change;
        mem_ctl.clr_addr = request.alarm_index;
        mem_ctl.wr_en    = wb_pend_reg && elig_reg[wb_addr_reg];
        mem_ctl.wr_addr  = wb_addr_reg;
        if (state_reg == ST_WALK)
        begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = walk_cnt_reg;
        end
        else if (state_reg == ST_FETCH)
        begin
            mem_ctl.rd_en   = idx_ok_reg;
            mem_ctl.rd_addr = req_reg.alarm_index;
        end
    end

    // result assembly when the addressed timer comes back
    assign rd_hr_wide = WORD_W'(rd_hr);

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = 1'b0;
        if (state_reg == ST_DONE)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            result_next.alarm_word = word_now;
            if (idx_ok_reg)
            begin
                result_next.selected_state = word_now[req_reg.alarm_index];
                result_next.hold_seconds   = rd_sec;
                result_next.hold_minutes   = rd_min;
                result_next.hold_hours     = rd_hr_wide[HOURS_OUT_W-1:0];
            end
            if (req_reg.command == CMD_SET)
            begin
                result_next.beep_request = (word_now != '0);
                result_next.beep_grade   = req_reg.alarm_grade;
            end
        end
    end

    aht_hold_mem #(
        .DEPTH  (ALARM_COUNT),
        .DATA_W (ENTRY_W)
    ) u_hold_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            alarm_bits_reg   <= '0;
            walk_cnt_reg     <= '0;
            wb_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            alarm_bits_reg   <= alarm_bits_next;
            walk_cnt_reg     <= walk_cnt_next;
            wb_pend_reg      <= wb_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= request;
            idx_ok_reg <= idx_ok_next;
        end
        elig_reg    <= elig_next;
        wb_addr_reg <= walk_cnt_reg;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the strobe comes only right after the result cycle of the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_DONE))
    else $error("result strobe without a finished item");

    // busy only rises on a started item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
    else $error("busy rose without start");

    // timer write-back only during the tick walk
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
    else $error("timer write outside the tick walk");

    // beep fields stay low for anything but a set item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && req_reg.command != CMD_SET)
        |=> (!result.beep_request && result.beep_grade == '0))
    else $error("beep fields on a non-set item");

endmodule

[sim/tb.sv]
// self-checking testbench for the alarm hold-time tracker
`timescale 1ns / 1ps

module tb;
    import aht_pkg::*;

    // cycle budget: about 1250 items, each as long as a tick item plus a long gap,
    // stay far below this
    localparam int CYCLE_LIMIT = 500000;
    // the longest item is a tick
    localparam int SETTLE_CYCLES = 40;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS = 1100;
    localparam logic [TIME_W-1:0] TIME_LAST = TIME_W'(ROLL_LIMIT - 1);

    // one queued command plus a flag that makes the driver wait for all results
    typedef struct {
        request_t req;
        bit       drain_first;
    } pending_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     result_valid;
    result_t  result;

    pending_t requests_to_send[$];
    result_t  reports_due[$];
    int       requests_taken = 0;
    int       reports_seen = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       hold_off = 0;
    bit       steady_run = 1'b0;
    bit       drain_next = 1'b0;

    // predicted tracker state: alarm word and one h:m:s timer per alarm
    logic [WORD_W-1:0]        alarm_bits_m = '0;
    logic [TIME_W-1:0]        held_sec [WORD_W] = '{default: '0};
    logic [TIME_W-1:0]        held_min [WORD_W] = '{default: '0};
    logic [HOUR_BITS_DEF-1:0] held_hr  [WORD_W] = '{default: '0};

    alarm_hold_time_tracker dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // applies one command to the predicted state and returns the report it causes
    function automatic result_t track_request(request_t rq);
        result_t rs;
        bit      idx_ok;
        int      i;
        rs = '0;
        idx_ok = int'(rq.alarm_index) < ALARM_COUNT_DEF;
        case (rq.command)
            CMD_TICK:
            begin
                // producer group is 16..27, stack group 0..15; 28 and up never age
                for (i = 0; i < TICK_SLOTS; i++)
                begin
                    if (alarm_bits_m[i] &&
                        ((i >= PRODUCER_FIRST) ? rq.producer_active : rq.stack_active))
                    begin
                        if (held_sec[i] == TIME_LAST)
                        begin
                            held_sec[i] = '0;
                            if (held_min[i] == TIME_LAST)
                            begin
                                held_min[i] = '0;
                                held_hr[i] = held_hr[i] + HOUR_BITS_DEF'(1);
                            end
                            else
                            begin
                                held_min[i] = held_min[i] + TIME_W'(1);
                            end
                        end
                        else
                        begin
                            held_sec[i] = held_sec[i] + TIME_W'(1);
                        end
                    end
                end
            end
            CMD_SET:
            begin
                // timer restarts only on a real change of the bit
                if (idx_ok && alarm_bits_m[rq.alarm_index] != rq.alarm_on)
                begin
                    held_sec[rq.alarm_index] = '0;
                    held_min[rq.alarm_index] = '0;
                    held_hr[rq.alarm_index] = '0;
                    alarm_bits_m[rq.alarm_index] = rq.alarm_on;
                end
                rs.beep_request = (alarm_bits_m != '0);
                rs.beep_grade = rq.alarm_grade;
            end
            CMD_CLEAR:
            begin
                alarm_bits_m = '0;
                for (i = 0; i < WORD_W; i++)
                begin
                    held_sec[i] = '0;
                    held_min[i] = '0;
                    held_hr[i] = '0;
                end
            end
            default:
            begin
                // read leaves the state alone
            end
        endcase
        rs.alarm_word = alarm_bits_m;
        if (idx_ok)
        begin
            rs.selected_state = alarm_bits_m[rq.alarm_index];
            rs.hold_seconds = held_sec[rq.alarm_index];
            rs.hold_minutes = held_min[rq.alarm_index];
            rs.hold_hours = held_hr[rq.alarm_index][HOURS_OUT_W-1:0];
        end
        return rs;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_item(input command_t c, input int idx, input bit on, input int grade,
                            input bit prod, input bit stack);
        pending_t p;
        p.req.command = c;
        p.req.alarm_index = IDX_W'(idx);
        p.req.alarm_on = on;
        p.req.alarm_grade = GRADE_W'(grade);
        p.req.producer_active = prod;
        p.req.stack_active = stack;
        p.drain_first = drain_next;
        drain_next = 1'b0;
        requests_to_send.push_back(p);
    endtask

    // a random item of the given command; fields the command ignores stay random
    task automatic add_random(input command_t c, input bit on);
        add_item(c, $urandom_range(31), on, $urandom_range(7),
                 $urandom_range(3) != 0, $urandom_range(3) != 0);
    endtask

    // driver: holds an item until the block takes it, then idles for a random gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                reports_due.push_back(track_request(request));
                requests_taken++;
                // rare switch into or out of a stretch with no gaps
                if ($urandom_range(49) == 0)
                begin
                    steady_run = !steady_run;
                end
                if (steady_run)
                begin
                    hold_off = 0;
                end
                else
                begin
                    case ($urandom_range(99)) inside
                        [0:54]:  hold_off = 0;
                        [55:87]: hold_off = $urandom_range(3, 1);
                        default: hold_off = $urandom_range(40, 8);
                    endcase
                end
            end
            if (start && busy)
            begin
                // item still waiting for the block, keep it on the port
            end
            else if (hold_off > 0)
            begin
                hold_off--;
                start <= 1'b0;
            end
            else if (requests_to_send.size() != 0 && requests_to_send[0].drain_first &&
                     requests_taken != reports_seen)
            begin
                start <= 1'b0;
            end
            else if (requests_to_send.size() != 0)
            begin
                request <= requests_to_send[0].req;
                requests_to_send.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result is checked against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            reports_seen <= reports_seen + 1;
            if (reports_due.size() == 0)
            begin
                $error("result with no pending item: alarm_word %0h", result.alarm_word);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("alarm_word", 64'(want.alarm_word), 64'(result.alarm_word));
                check_field("selected_state", 64'(want.selected_state),
                            64'(result.selected_state));
                check_field("hold_seconds", 64'(want.hold_seconds),
                            64'(result.hold_seconds));
                check_field("hold_minutes", 64'(want.hold_minutes),
                            64'(result.hold_minutes));
                check_field("hold_hours", 64'(want.hold_hours), 64'(result.hold_hours));
                check_field("beep_request", 64'(want.beep_request),
                            64'(result.beep_request));
                check_field("beep_grade", 64'(want.beep_grade), 64'(result.beep_grade));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[alarm_hold_time_tracker] ERROR");
            $finish;
        end
    end

    initial
    begin
        int  added;
        int  n;
        int  k;
        int  kind;

        // directed: empty state, group boundaries, top alarms, repeated set,
        // every tick condition, clear and beeps with nothing active
        add_item(CMD_READ, 0, 1'b1, 7, 1'b1, 1'b1);
        add_item(CMD_TICK, 31, 1'b1, 7, 1'b1, 1'b1);
        add_item(CMD_SET, 0, 1'b1, 7, 1'b0, 1'b0);
        add_item(CMD_SET, 31, 1'b1, 0, 1'b1, 1'b1);
        add_item(CMD_SET, 15, 1'b1, 3, 1'b0, 1'b0);
        add_item(CMD_SET, 16, 1'b1, 5, 1'b0, 1'b0);
        add_item(CMD_SET, 27, 1'b1, 1, 1'b0, 1'b0);
        add_item(CMD_SET, 28, 1'b1, 6, 1'b0, 1'b0);
        // both groups in one tick, then each alone, then neither
        add_item(CMD_TICK, 0, 1'b0, 0, 1'b1, 1'b1);
        add_item(CMD_TICK, 16, 1'b0, 0, 1'b1, 1'b0);
        add_item(CMD_TICK, 15, 1'b1, 7, 1'b0, 1'b1);
        add_item(CMD_TICK, 27, 1'b1, 7, 1'b0, 1'b0);
        // set to the state it already has: timer must keep running
        add_item(CMD_SET, 0, 1'b1, 2, 1'b1, 1'b1);
        add_item(CMD_READ, 15, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_READ, 16, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_READ, 27, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_READ, 28, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_READ, 31, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_SET, 16, 1'b0, 4, 1'b0, 1'b0);
        add_item(CMD_READ, 16, 1'b1, 7, 1'b1, 1'b1);
        add_item(CMD_CLEAR, 0, 1'b1, 7, 1'b1, 1'b1);
        add_item(CMD_READ, 31, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_SET, 5, 1'b0, 7, 1'b0, 1'b0);
        add_item(CMD_SET, 31, 1'b0, 0, 1'b0, 1'b0);
        add_item(CMD_TICK, 0, 1'b0, 0, 1'b1, 1'b1);

        // random part in episodes: alarm setups, long tick runs so timers roll seconds
        // over into minutes, read bursts, and the odd clear
        added = 0;
        drain_next = 1'b1;
        while (added < RANDOM_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                n = $urandom_range(120, 5);
                for (k = 0; k < n; k++)
                begin
                    add_random(($urandom_range(9) == 0) ? CMD_READ : CMD_TICK,
                               1'($urandom_range(1)));
                end
            end
            else if (kind < 70)
            begin
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++)
                begin
                    add_random(CMD_SET, $urandom_range(3) != 0);
                end
            end
            else if (kind < 96)
            begin
                n = $urandom_range(8, 1);
                for (k = 0; k < n; k++)
                begin
                    add_random(CMD_READ, 1'($urandom_range(1)));
                end
            end
            else
            begin
                n = 1;
                drain_next = ($urandom_range(2) == 0);
                add_random(CMD_CLEAR, 1'($urandom_range(1)));
            end
            added += n;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_to_send.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (reports_seen != requests_taken)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (reports_due.size() != 0)
        begin
            $error("%0d results never arrived", reports_due.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("[alarm_hold_time_tracker] OK");
        end
        else
        begin
            $display("[alarm_hold_time_tracker] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/aht_pkg.sv
hw/rtl/aht_hold_mem.sv
hw/rtl/alarm_hold_time_tracker.sv
sim/tb.sv
